FILE: hw/rtl/mwsm_pkg.sv
// ----------------------------------------------------------------------------
// mwsm_pkg
// Shared widths, constants and types of the mecanum wheel speed mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package mwsm_pkg;

    localparam int FIELD_W    = 16;
    localparam int GAIN_W     = 9;
    localparam int GAIN_FRAC  = 8;
    localparam int GAIN_ONE   = 1 << GAIN_FRAC;
    localparam int FULL_SCALE = 25600;
    localparam int NUM_WHEELS = 4;

    // wheel sums of three 16 bit terms, signed, and their magnitudes
    localparam int SUM_W = FIELD_W + 2;
    localparam int MAG_W = SUM_W - 1;

    // quotient bits needed to hold full scale
    localparam int FS_W    = $clog2(FULL_SCALE + 1);
    localparam int PROD_W  = MAG_W + FS_W;
    localparam int GPROD_W = FS_W + GAIN_W;
    localparam int OMAG_W  = GPROD_W - GAIN_FRAC;

    // queue between front and back, depth is a power of two
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam int FL = 0;
    localparam int FR = 1;
    localparam int BL = 2;
    localparam int BR = 3;

    // one classified command: wheel signs, magnitudes and the divisor
    typedef struct packed {
        logic [NUM_WHEELS-1:0]            neg;
        logic [NUM_WHEELS-1:0][MAG_W-1:0] mag;
        logic [MAG_W-1:0]                 div;
    } mix_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mwsm_ifs.sv
// ----------------------------------------------------------------------------
// mwsm channel interfaces
// Command, wheel speed and gain write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mwsm_cmd_if;
    import mwsm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] forward_speed;
    logic signed [FIELD_W-1:0] sideways_speed;
    logic signed [FIELD_W-1:0] turn_rate;

    modport source (
        output valid, forward_speed, sideways_speed, turn_rate,
        input  ready
    );
    modport sink (
        input  valid, forward_speed, sideways_speed, turn_rate,
        output ready
    );
endinterface

interface mwsm_wheel_if;
    import mwsm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] front_left_speed;
    logic signed [FIELD_W-1:0] front_right_speed;
    logic signed [FIELD_W-1:0] back_left_speed;
    logic signed [FIELD_W-1:0] back_right_speed;

    modport source (
        output valid, front_left_speed, front_right_speed,
               back_left_speed, back_right_speed,
        input  ready
    );
    modport sink (
        input  valid, front_left_speed, front_right_speed,
               back_left_speed, back_right_speed,
        output ready
    );
endinterface

interface mwsm_cfg_if;
    import mwsm_pkg::*;

    logic              valid;
    logic              ready;
    logic [GAIN_W-1:0] speed_gain;

    modport source (
        output valid, speed_gain,
        input  ready
    );
    modport sink (
        input  valid, speed_gain,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/mwsm_front.sv
// ----------------------------------------------------------------------------
// mwsm_front
// Accepts commands, forms the four wheel sums, their magnitudes and the
// normalizing divisor, and hands the result to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mwsm_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    mwsm_cmd_if.sink           cmd,
    output mwsm_pkg::mix_t     push_data,
    output logic               push_valid,
    input  wire logic          push_ready
);
    import mwsm_pkg::*;

    logic                    sum_vld_reg;
    logic                    sum_vld_next;
    logic signed [SUM_W-1:0] sum_reg  [NUM_WHEELS];
    logic signed [SUM_W-1:0] sum_next [NUM_WHEELS];
    logic                    advance;

    logic [MAG_W-1:0] mag [NUM_WHEELS];
    logic [MAG_W-1:0] max01;
    logic [MAG_W-1:0] max23;
    logic [MAG_W-1:0] max_all;

    assign advance   = !sum_vld_reg || push_ready;
    assign cmd.ready = advance;

    always_comb
    begin
        logic signed [SUM_W-1:0] vy;
        logic signed [SUM_W-1:0] vx;
        logic signed [SUM_W-1:0] w;
        vy = SUM_W'(cmd.forward_speed);
        vx = SUM_W'(cmd.sideways_speed);
        w  = SUM_W'(cmd.turn_rate);
        sum_next[FL] = vy + vx + w;
        sum_next[FR] = vy - vx - w;
        sum_next[BL] = vy - vx + w;
        sum_next[BR] = vy + vx - w;
        sum_vld_next = advance ? cmd.valid : sum_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_vld_reg <= 1'b0;
        end
        else
        begin
            sum_vld_reg <= sum_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && cmd.valid)
        begin
            sum_reg <= sum_next;
        end
    end

    always_comb
    begin
        logic signed [SUM_W-1:0] neg_sum;
        for (int l = 0; l < NUM_WHEELS; l++)
        begin
            neg_sum = -sum_reg[l];
            mag[l]  = sum_reg[l][SUM_W-1] ? neg_sum[MAG_W-1:0] : sum_reg[l][MAG_W-1:0];
        end
        max01   = (mag[FL] > mag[FR]) ? mag[FL] : mag[FR];
        max23   = (mag[BL] > mag[BR]) ? mag[BL] : mag[BR];
        max_all = (max01 > max23) ? max01 : max23;
    end

    // below full scale the divisor is full scale itself, so the divide is exact
    always_comb
    begin
        for (int l = 0; l < NUM_WHEELS; l++)
        begin
            push_data.neg[l] = sum_reg[l][SUM_W-1];
            push_data.mag[l] = mag[l];
        end
        push_data.div = (max_all > MAG_W'(FULL_SCALE)) ? max_all : MAG_W'(FULL_SCALE);
    end

    assign push_valid = sum_vld_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/mwsm_queue.sv
// ----------------------------------------------------------------------------
// mwsm_queue
// Short first-in first-out queue of classified commands between the front
// and the divider pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module mwsm_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mwsm_pkg::mix_t  push_data,
    input  wire logic            push_valid,
    output logic                 push_ready,
    output mwsm_pkg::mix_t       pop_data,
    output logic                 pop_valid,
    input  wire logic            pop_ready
);
    import mwsm_pkg::*;

    mix_t            mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_next;
    logic [Q_CW-1:0] count_reg;
    logic [Q_CW-1:0] count_next;
    logic            push;
    logic            pop;

    assign push_ready = (count_reg != Q_CW'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + Q_CW'(push) - Q_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg == $past(count_reg) + Q_CW'($past(push)) - Q_CW'($past(pop)))
        else $error("queue count does not follow push and pop");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        Q_AW'(wr_ptr_reg - rd_ptr_reg) == count_reg[Q_AW-1:0])
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

FILE: hw/rtl/mwsm_back.sv
// ----------------------------------------------------------------------------
// mwsm_back
// Normalizes the wheel magnitudes through a pipelined restoring divider,
// one quotient bit per stage, applies the speed gain and drives the result.
// ----------------------------------------------------------------------------
`default_nettype none

module mwsm_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mwsm_pkg::mix_t  pop_data,
    input  wire logic            pop_valid,
    output logic                 pop_ready,
    mwsm_cfg_if.sink             cfg,
    mwsm_wheel_if.source         wheels
);
    import mwsm_pkg::*;

    logic [GAIN_W-1:0] gain_reg;
    logic              en;

    // divider pipeline, stage 0 holds the scaled dividend
    logic [FS_W:0]            vld_reg;
    logic [MAG_W-1:0]         rem_reg [0:FS_W][NUM_WHEELS];
    logic [FS_W-1:0]          nlo_reg [0:FS_W][NUM_WHEELS];
    logic [FS_W-1:0]          quo_reg [0:FS_W][NUM_WHEELS];
    logic [MAG_W-1:0]         div_reg [0:FS_W];
    logic [NUM_WHEELS-1:0]    neg_reg [0:FS_W];
    logic [PROD_W-1:0]        dvd     [NUM_WHEELS];
    logic [MAG_W-1:0]         rem_nx  [1:FS_W][NUM_WHEELS];
    logic [NUM_WHEELS-1:0]    bit_nx  [1:FS_W];

    logic                     g_vld_reg;
    logic [GPROD_W-1:0]       gprod_reg [NUM_WHEELS];
    logic [NUM_WHEELS-1:0]    g_neg_reg;

    logic                      out_vld_reg;
    logic signed [FIELD_W-1:0] spd_reg  [NUM_WHEELS];
    logic signed [FIELD_W-1:0] spd_next [NUM_WHEELS];

    assign en        = !out_vld_reg || wheels.ready;
    assign pop_ready = en;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_W'(GAIN_ONE);
        end
        else if (cfg.valid)
        begin
            gain_reg <= cfg.speed_gain;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            g_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[FS_W-1:0], pop_valid};
            g_vld_reg   <= vld_reg[FS_W];
            out_vld_reg <= g_vld_reg;
        end
    end

    always_comb
    begin
        for (int l = 0; l < NUM_WHEELS; l++)
        begin
            dvd[l] = PROD_W'(pop_data.mag[l]) * PROD_W'(FULL_SCALE);
        end
    end

    // one trial subtraction per stage and wheel
    always_comb
    begin
        logic [MAG_W:0] trial;
        logic [MAG_W:0] diff;
        logic           take;
        for (int s = 1; s <= FS_W; s++)
        begin
            for (int l = 0; l < NUM_WHEELS; l++)
            begin
                trial        = {rem_reg[s-1][l], nlo_reg[s-1][l][FS_W-1]};
                diff         = trial - {1'b0, div_reg[s-1]};
                take         = (trial >= {1'b0, div_reg[s-1]});
                bit_nx[s][l] = take;
                rem_nx[s][l] = take ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
            end
        end
    end

    // quotient fits FS_W bits, so the top of the dividend starts below the divisor
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < NUM_WHEELS; l++)
            begin
                rem_reg[0][l] <= dvd[l][PROD_W-1:FS_W];
                nlo_reg[0][l] <= dvd[l][FS_W-1:0];
                quo_reg[0][l] <= '0;
            end
            div_reg[0] <= pop_data.div;
            neg_reg[0] <= pop_data.neg;
            for (int s = 1; s <= FS_W; s++)
            begin
                for (int l = 0; l < NUM_WHEELS; l++)
                begin
                    rem_reg[s][l] <= rem_nx[s][l];
                    nlo_reg[s][l] <= {nlo_reg[s-1][l][FS_W-2:0], 1'b0};
                    quo_reg[s][l] <= {quo_reg[s-1][l][FS_W-2:0], bit_nx[s][l]};
                end
                div_reg[s] <= div_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < NUM_WHEELS; l++)
            begin
                gprod_reg[l] <= GPROD_W'(quo_reg[FS_W][l]) * GPROD_W'(gain_reg);
            end
            g_neg_reg <= neg_reg[FS_W];
        end
    end

    // drop the gain fraction, saturate a gain above one, then restore the sign
    always_comb
    begin
        logic [OMAG_W-1:0]  om;
        logic [FIELD_W-1:0] cm;
        for (int l = 0; l < NUM_WHEELS; l++)
        begin
            om = gprod_reg[l][GPROD_W-1:GAIN_FRAC];
            cm = (om > OMAG_W'(FULL_SCALE)) ? FIELD_W'(FULL_SCALE) : FIELD_W'(om);
            spd_next[l] = g_neg_reg[l] ? -$signed(cm) : $signed(cm);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            spd_reg <= spd_next;
        end
    end

    assign wheels.valid             = out_vld_reg;
    assign wheels.front_left_speed  = spd_reg[FL];
    assign wheels.front_right_speed = spd_reg[FR];
    assign wheels.back_left_speed   = spd_reg[BL];
    assign wheels.back_right_speed  = spd_reg[BR];

    a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[FS_W] |->
            (quo_reg[FS_W][FL] <= FS_W'(FULL_SCALE)) && (quo_reg[FS_W][FR] <= FS_W'(FULL_SCALE)) &&
            (quo_reg[FS_W][BL] <= FS_W'(FULL_SCALE)) && (quo_reg[FS_W][BR] <= FS_W'(FULL_SCALE)))
        else $error("normalized wheel magnitude above full scale");

    a_out_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |->
            (spd_reg[FL] <= FULL_SCALE) && (spd_reg[FL] >= -FULL_SCALE) &&
            (spd_reg[FR] <= FULL_SCALE) && (spd_reg[FR] >= -FULL_SCALE) &&
            (spd_reg[BL] <= FULL_SCALE) && (spd_reg[BL] >= -FULL_SCALE) &&
            (spd_reg[BR] <= FULL_SCALE) && (spd_reg[BR] >= -FULL_SCALE))
        else $error("wheel speed outside full scale");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> (vld_reg == $past(vld_reg)) && (g_vld_reg == $past(g_vld_reg)))
        else $error("divider pipeline moved while output stalled");

endmodule

`default_nettype wire

FILE: hw/rtl/mecanum_wheel_speed_mixer.sv
// ----------------------------------------------------------------------------
// mecanum_wheel_speed_mixer
// Mecanum inverse kinematics with normalization to full scale and speed gain.
// ----------------------------------------------------------------------------
// Takes one command (forward, sideways, turn, percent times 256) per cycle
// when not back-pressured and returns one set of four wheel speeds per command,
// in order. A command passes the front register that forms the wheel sums and
// divisor, a four-entry queue, the register that loads the scaled dividend, a
// 15-stage restoring divider that produces one quotient bit per stage for all
// four wheels, the gain multiply register and the output register. The divider
// pipeline stalls as a whole while a result waits on the output; the queue and
// the front register take up to five more commands meanwhile. speed_gain
// resets to 256 (unity) and should only be written while no command
// is in flight.
`default_nettype none

module mecanum_wheel_speed_mixer (
    input  wire logic    clk,
    input  wire logic    rst_n,
    mwsm_cmd_if.sink     cmd,
    mwsm_cfg_if.sink     cfg,
    mwsm_wheel_if.source wheels
);
    import mwsm_pkg::*;

    mix_t push_data;
    logic push_valid;
    logic push_ready;
    mix_t pop_data;
    logic pop_valid;
    logic pop_ready;

    mwsm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    mwsm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    mwsm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .cfg        (cfg),
        .wheels     (wheels)
    );

endmodule

`default_nettype wire

FILE: tb/mecanum_wheel_speed_mixer_test.sv
// ----------------------------------------------------------------------------
// mecanum_wheel_speed_mixer_test
// Drives motion commands into the wheel speed mixer under random source gaps
// and sink stalls. Each command's four wheel speeds are predicted from the
// command and the current speed gain, then checked in order against the output.
// ----------------------------------------------------------------------------
module mecanum_wheel_speed_mixer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mwsm_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_CYCLES = 250;
    localparam int DRAIN_WAIT  = 40;
    localparam int MAX_PRINTS  = 100;

    typedef struct packed {
        logic signed [FIELD_W-1:0] fwd;
        logic signed [FIELD_W-1:0] side;
        logic signed [FIELD_W-1:0] turn;
    } cmd_t;

    typedef logic [NUM_WHEELS-1:0][FIELD_W-1:0] speed_set_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_e;

    logic clk;
    logic rst_n;

    mwsm_cmd_if   cmd_ch ();
    mwsm_cfg_if   cfg_ch ();
    mwsm_wheel_if wheel_ch ();

    mecanum_wheel_speed_mixer DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .cfg    (cfg_ch),
        .wheels (wheel_ch)
    );

    cmd_t       pending_cmds [$];
    speed_set_t wheel_exp [$];
    string      wheel_name [NUM_WHEELS] = '{"front_left", "front_right",
                                            "back_left", "back_right"};

    logic [GAIN_W-1:0] gain_now;
    bit                cmd_taken;
    int                burst_left;
    int                gap_left;
    int                hold_requests;
    int                hold_served;
    int                hold_left;
    int                mode_left;
    int                beat_count;
    rx_mode_e          rx_mode;
    int                errors;
    int                cmd_count;
    int                result_count;
    int                scaled_count;
    int                gain_writes;
    int                idle_cycles;

    cmd_t       acc_cmd;
    speed_set_t got;
    speed_set_t want;
    bit         acc_scaled;

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // inverse kinematics, normalization to full scale, then the speed gain
    function automatic speed_set_t mix_wheels(input cmd_t c,
                                              input logic [GAIN_W-1:0] gain,
                                              output bit scaled);
        longint     vy;
        longint     vx;
        longint     rot;
        longint     peak;
        longint     v;
        longint     sum [NUM_WHEELS];
        speed_set_t r;
        int         i;
        vy = longint'(c.fwd);
        vx = longint'(c.side);
        rot = longint'(c.turn);
        sum[FL] = vy + vx + rot;
        sum[FR] = vy - vx - rot;
        sum[BL] = vy - vx + rot;
        sum[BR] = vy + vx - rot;
        peak = 0;
        for (i = 0; i < NUM_WHEELS; i++)
        begin
            v = (sum[i] < 0) ? -sum[i] : sum[i];
            if (v > peak)
                peak = v;
        end
        scaled = (peak > FULL_SCALE);
        for (i = 0; i < NUM_WHEELS; i++)
        begin
            v = sum[i];
            if (scaled)
                v = (v * FULL_SCALE) / peak;
            v = (v * longint'(gain)) / GAIN_ONE;
            if (v > FULL_SCALE)
                v = longint'(FULL_SCALE);
            if (v < -FULL_SCALE)
                v = -longint'(FULL_SCALE);
            r[i] = v[FIELD_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [FIELD_W-1:0] pick_speed(input int kind);
        logic signed [FIELD_W-1:0] s;
        if (kind < 4)
            s = FIELD_W'($urandom_range(0, 17066) - 8533);    // sums stay under full scale
        else if (kind < 7)
            s = FIELD_W'($urandom_range(0, 2 * FULL_SCALE) - FULL_SCALE);
        else if (kind < 9)
            s = FIELD_W'($urandom());
        else
        begin
            case ($urandom_range(0, 7))
                0: s = '0;
                1: s = FIELD_W'(1);
                2: s = FIELD_W'(-1);
                3: s = FIELD_W'(FULL_SCALE);
                4: s = FIELD_W'(-FULL_SCALE);
                5: s = 16'sh7fff;
                6: s = 16'sh8000;
                default: s = FIELD_W'(FULL_SCALE / 2);
            endcase
        end
        return s;
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        int   kind;
        kind = $urandom_range(0, 9);
        c.fwd = pick_speed(kind);
        c.side = pick_speed(kind);
        c.turn = pick_speed(kind);
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        if (errors < MAX_PRINTS)
            $display("%t mismatch: %s", $realtime, msg);
        errors++;
    endtask

    task automatic push_cmd(input int f, input int s, input int t);
        cmd_t c;
        c.fwd = f[FIELD_W-1:0];
        c.side = s[FIELD_W-1:0];
        c.turn = t[FIELD_W-1:0];
        pending_cmds.push_back(c);
    endtask

    task automatic push_directed();
        push_cmd(0, 0, 0);
        push_cmd(FULL_SCALE, 0, 0);
        push_cmd(0, FULL_SCALE, 0);
        push_cmd(0, 0, FULL_SCALE);
        push_cmd(-FULL_SCALE, 0, 0);
        push_cmd(0, -FULL_SCALE, 0);
        push_cmd(0, 0, -FULL_SCALE);
        push_cmd(FULL_SCALE, FULL_SCALE, FULL_SCALE);
        push_cmd(-FULL_SCALE, -FULL_SCALE, -FULL_SCALE);
        // peak exactly at full scale, then one above it
        push_cmd(12800, 12800, 0);
        push_cmd(12800, 12800, 1);
        push_cmd(32767, 32767, 32767);
        push_cmd(-32768, -32768, -32768);
        push_cmd(-32768, 32767, -32768);
        push_cmd(32767, -32768, 32767);
        push_cmd(1, -1, 1);
        push_cmd(-1, 0, 0);
        push_cmd(100, 200, -300);
        push_cmd(FULL_SCALE, -FULL_SCALE, FULL_SCALE);
        push_cmd(8533, 8533, 8534);
    endtask

    task automatic push_random(input int n);
        repeat (n) pending_cmds.push_back(random_cmd());
    endtask

    // block is idle once every command is out and the pipeline has emptied
    task automatic settle();
        while (pending_cmds.size() != 0 || wheel_exp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_gain(input logic [GAIN_W-1:0] g);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.speed_gain <= g;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        gain_now = g;
        gain_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // command source: bursts of items with random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
            cmd_ch.valid <= 1'b0;
        else if (!(cmd_ch.valid && !cmd_taken))
        begin
            cmd_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                cmd_ch.valid <= 1'b0;
            end
            else if (pending_cmds.size() == 0)
                cmd_ch.valid <= 1'b0;
            else
            begin
                cmd_ch.valid <= 1'b1;
                cmd_ch.forward_speed <= pending_cmds[0].fwd;
                cmd_ch.sideways_speed <= pending_cmds[0].side;
                cmd_ch.turn_rate <= pending_cmds[0].turn;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end
            end
        end
    end

    // accepted command: predict its wheel speeds
    always @(posedge clk)
    begin
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
        begin
            acc_cmd.fwd = cmd_ch.forward_speed;
            acc_cmd.side = cmd_ch.sideways_speed;
            acc_cmd.turn = cmd_ch.turn_rate;
            wheel_exp.push_back(mix_wheels(acc_cmd, gain_now, acc_scaled));
            void'(pending_cmds.pop_front());
            cmd_count++;
            if (acc_scaled)
                scaled_count++;
            cmd_taken = 1'b1;
        end
    end

    // wheel speed sink: stall pattern switches among four random modes
    always @(negedge clk)
    begin
        if (!rst_n)
            wheel_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            wheel_ch.ready <= 1'b0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES - 1;
            wheel_ch.ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode = rx_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            beat_count++;
            case (rx_mode)
                RX_OPEN:   wheel_ch.ready <= 1'b1;
                RX_COIN:   wheel_ch.ready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE: wheel_ch.ready <= ($urandom_range(0, 3) == 0);
                default:   wheel_ch.ready <= (beat_count % 5 != 4);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && wheel_ch.valid && wheel_ch.ready)
        begin
            got[FL] = wheel_ch.front_left_speed;
            got[FR] = wheel_ch.front_right_speed;
            got[BL] = wheel_ch.back_left_speed;
            got[BR] = wheel_ch.back_right_speed;
            if (wheel_exp.size() == 0)
                report_mismatch($sformatf("wheel speeds %0d %0d %0d %0d with no command waiting",
                    $signed(got[FL]), $signed(got[FR]), $signed(got[BL]), $signed(got[BR])));
            else
            begin
                want = wheel_exp.pop_front();
                for (int w = 0; w < NUM_WHEELS; w++)
                    if (got[w] !== want[w])
                        report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                            result_count, wheel_name[w], $signed(got[w]), $signed(want[w])));
            end
            result_count++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_ch.valid && cmd_ch.ready) || (wheel_ch.valid && wheel_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                    idle_cycles, wheel_exp.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    logic [GAIN_W-1:0] gain_plan [7] = '{511, 0, 1, 256, 128, 300, 255};
    int                plan_len [7]  = '{100, 100, 100, 300, 200, 150, 200};

    initial
    begin
        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.forward_speed = '0;
        cmd_ch.sideways_speed = '0;
        cmd_ch.turn_rate = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.speed_gain = GAIN_W'(GAIN_ONE);
        wheel_ch.ready = 1'b0;
        gain_now = GAIN_W'(GAIN_ONE);
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset gain first, then the same commands at the largest gain
        push_directed();
        settle();
        for (int p = 0; p < 7; p++)
        begin
            write_gain(gain_plan[p]);
            if (p == 0)
                push_directed();
            push_random(plan_len[p]);
            if (gain_plan[p] == GAIN_ONE)
            begin
                // long sink hold while commands keep coming
                repeat (30) @(posedge clk);
                hold_requests++;
            end
            settle();
        end
        repeat (4)
        begin
            write_gain(GAIN_W'($urandom_range(0, (1 << GAIN_W) - 1)));
            push_random(120);
            settle();
        end

        $display("checked %0d commands (%0d normalized) over %0d gain settings",
            cmd_count, scaled_count, gain_writes + 1);
        $display("%0d wheel speed sets compared, %0d field mismatches", result_count, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/mwsm_pkg.sv
hw/rtl/mwsm_ifs.sv
hw/rtl/mwsm_front.sv
hw/rtl/mwsm_queue.sv
hw/rtl/mwsm_back.sv
hw/rtl/mecanum_wheel_speed_mixer.sv
tb/mecanum_wheel_speed_mixer_test.sv
